@@ design/ead_pkg.sv @@
// Package for the edge anchor detector: default sizes, register indexes,
// and the angle quantization limits. No dependencies.
package ead_pkg;

  // Default line buffer depth and gradient width of the top level.
  localparam int MAX_WIDTH_DEF = 2048;
  localparam int GRAD_BITS_DEF = 16;

  // Frame size limits and register reset values.
  localparam int MIN_DIM      = 3;
  localparam int HEIGHT_LIMIT = 2048;
  localparam logic [11:0] FRAME_WIDTH_RST  = 12'd640;
  localparam logic [11:0] FRAME_HEIGHT_RST = 12'd480;

  // Port widths fixed by the word format.
  localparam int MAG_BITS   = 16;
  localparam int ANGLE_BITS = 15;
  localparam int POS_BITS   = 11;
  localparam int CFG_BITS   = 16;
  localparam int DIM_BITS   = 12;

  // Angle scale: pi is 8192, so pi/4 is 2048 and 3pi/4 is 6144.
  localparam logic [ANGLE_BITS-1:0] QUARTER_PI       = 15'd2048;
  localparam logic [ANGLE_BITS-1:0] THREE_QUARTER_PI = 15'd6144;
  localparam logic [ANGLE_BITS:0]   FULL_TURN        = 16'h8000;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_MIN_GRAD      = 2'd0,
    REG_ANCHOR_THRESH = 2'd1,
    REG_FRAME_WIDTH   = 2'd2,
    REG_FRAME_HEIGHT  = 2'd3
  } cfg_reg_t;

endpackage

@@ design/edge_anchor_detector.sv @@
// Edge anchor detector top level: position counters, line buffer memories,
// anchor decision stage and output register. Depends on ead_pkg.
//
// Usage: gradient words (grad_mag, grad_angle) enter in raster order on the
// in_valid/in_ready channel. Each word of rows 1 to height-1 yields one result
// word on out_valid/out_ready for the pixel straight above it (row minus
// one); words of row 0 yield nothing. frame_last marks the result of the
// last input pixel of a frame. Border pixels are never anchors.
// Configuration is written through cfg_write/cfg_index/cfg_data while the
// block is idle; frame_width and frame_height are clamped to 3..MAX_WIDTH and
// 3..2048.
// An accepted word is held in the decision stage registers, and its result
// then moves into the output register; a stalled receiver can hold it there.
// Throughput: one word per clock while the output does not stall, set by one
// read-modify-write of the line buffer entries at the pixel's column: read in
// the accept cycle, written back when the decision stage retires.
// Reset clears counters, registers and the anchor row fill count; the line
// buffers need no clearing pass, so the block is ready right after reset.
// When the receiver stalls, the output register holds its word, the decision
// stage holds the next one, and in_ready drops until the output drains.
module edge_anchor_detector #(
  parameter int MAX_WIDTH = ead_pkg::MAX_WIDTH_DEF,
  parameter int GRAD_BITS = ead_pkg::GRAD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration write port
  input  logic                                cfg_write,
  input  logic [1:0]                          cfg_index,
  input  logic [ead_pkg::CFG_BITS-1:0]        cfg_data,
  // Input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [ead_pkg::MAG_BITS-1:0]        grad_mag,
  input  logic signed [ead_pkg::ANGLE_BITS-1:0] grad_angle,
  // Output channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                is_anchor,
  output logic [ead_pkg::POS_BITS-1:0]        pix_col,
  output logic [ead_pkg::POS_BITS-1:0]        pix_row,
  output logic                                frame_last
);

  import ead_pkg::*;

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int GW = (GRAD_BITS < MAG_BITS) ? GRAD_BITS : MAG_BITS;
  localparam int SW = MAG_BITS + 1;

  // Configuration registers
  logic [CFG_BITS-1:0] min_grad;
  logic [CFG_BITS-1:0] anchor_thresh;
  logic [DIM_BITS-1:0] frame_width;
  logic [DIM_BITS-1:0] frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_grad      <= '0;
      anchor_thresh <= '0;
      frame_width   <= FRAME_WIDTH_RST;
      frame_height  <= FRAME_HEIGHT_RST;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MIN_GRAD:      min_grad      <= cfg_data;
        REG_ANCHOR_THRESH: anchor_thresh <= cfg_data;
        REG_FRAME_WIDTH:   frame_width   <= cfg_data[DIM_BITS-1:0];
        REG_FRAME_HEIGHT:  frame_height  <= cfg_data[DIM_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Clamped frame dimensions.
  logic [WW-1:0]       width;
  logic [DIM_BITS-1:0] height;

  always_comb begin
    if (32'(frame_width) < MIN_DIM) begin
      width = WW'(MIN_DIM);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      width = WW'(MAX_WIDTH);
    end else begin
      width = WW'(frame_width);
    end
    if (32'(frame_height) < MIN_DIM) begin
      height = DIM_BITS'(MIN_DIM);
    end else if (32'(frame_height) > HEIGHT_LIMIT) begin
      height = DIM_BITS'(HEIGHT_LIMIT);
    end else begin
      height = frame_height;
    end
  end

  // Handshake and stage control
  logic s1_valid;
  logic s1_emit;
  logic s1_go;
  logic out_free;
  logic accept;

  assign out_free = !out_valid || out_ready;
  assign s1_go    = s1_valid && (out_free || !s1_emit);
  assign in_ready = !s1_valid || s1_go;
  assign accept   = in_valid && in_ready;

  // Position of the incoming pixel and of the next one.
  logic [AW-1:0]        col_count;
  logic [POS_BITS-1:0]  row_count;
  logic [AW-1:0]        col_count_next;
  logic [POS_BITS-1:0]  row_count_next;
  logic                 col_wrap;
  logic [AW-1:0]        cur_x;
  logic [DIM_BITS-1:0]  row_step;
  logic [POS_BITS-1:0]  cur_y;
  logic [WW-1:0]        x_inc;
  logic [DIM_BITS-1:0]  y_inc;
  logic                 x_first;
  logic                 x_last;
  logic                 y_first;
  logic                 y_last;
  logic [AW-1:0]        right_addr;

  always_comb begin
    col_wrap = WW'(col_count) >= width;
    cur_x    = col_wrap ? '0 : col_count;
    row_step = col_wrap ? DIM_BITS'(row_count) + 1'b1 : DIM_BITS'(row_count);
    cur_y    = (row_step >= height) ? '0 : row_step[POS_BITS-1:0];

    x_inc    = WW'(cur_x) + 1'b1;
    y_inc    = DIM_BITS'(cur_y) + 1'b1;
    x_first  = cur_x == '0;
    x_last   = x_inc == width;
    y_first  = cur_y == '0;
    y_last   = y_inc == height;
    right_addr = x_inc[AW-1:0];

    if (x_inc >= width) begin
      col_count_next = '0;
      row_count_next = (y_inc >= height) ? '0 : y_inc[POS_BITS-1:0];
    end else begin
      col_count_next = x_inc[AW-1:0];
      row_count_next = cur_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

  // Masked gradient (zero on the frame border) and orientation bit.
  logic [GW-1:0]         g_in;
  logic [ANGLE_BITS-1:0] ang_bits;
  logic [ANGLE_BITS-1:0] ang_mag;
  logic                  orient_in;

  always_comb begin
    g_in = (x_first || x_last || y_first || y_last) ? '0 : grad_mag[GW-1:0];
    ang_bits = grad_angle;
    ang_mag  = ang_bits[ANGLE_BITS-1] ?
               ANGLE_BITS'(FULL_TURN - {1'b0, ang_bits}) : ang_bits;
    // One means compare with left and right neighbors.
    orient_in = (ang_mag < QUARTER_PI) || (ang_mag > THREE_QUARTER_PI);
  end

  // Decision stage registers (pixel data travelling with the memory reads).
  logic [AW-1:0]       s1_x;
  logic [POS_BITS-1:0] s1_row;
  logic [GW-1:0]       s1_g_in;
  logic                s1_orient_in;
  logic                s1_border;
  logic                s1_last_col;
  logic                s1_frame_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_x          <= cur_x;
      s1_row        <= cur_y - 1'b1;
      s1_emit       <= !y_first;
      s1_g_in       <= g_in;
      s1_orient_in  <= orient_in;
      // The decided pixel sits one row up; its top row is row 0.
      s1_border     <= x_first || x_last || (cur_y == POS_BITS'(1));
      s1_last_col   <= x_last;
      s1_frame_last <= y_last && x_last;
    end
  end

  // Line buffer memories. Reads happen on accept, write-back when the
  // decision stage retires; the two always touch different columns.
  logic [GW-1:0] grad_mid   [MAX_WIDTH];
  logic [GW-1:0] grad_above [MAX_WIDTH];
  logic          orient_mid [MAX_WIDTH];
  logic          anchor_above [MAX_WIDTH];

  logic [GW-1:0] mid_rd;
  logic [GW-1:0] right_rd;
  logic [GW-1:0] above_rd;
  logic          orient_rd;
  logic          anchor_rd;
  logic          anchor;

  always_ff @(posedge clk) begin
    if (accept) begin
      mid_rd    <= grad_mid[cur_x];
      right_rd  <= grad_mid[right_addr];
      above_rd  <= grad_above[cur_x];
      orient_rd <= orient_mid[cur_x];
      anchor_rd <= anchor_above[cur_x];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      grad_above[s1_x] <= mid_rd;
      grad_mid[s1_x]   <= s1_g_in;
      orient_mid[s1_x] <= s1_orient_in;
      if (s1_emit) begin
        anchor_above[s1_x] <= anchor;
      end
    end
  end

  // Anchor rows are written from column 0 upward, so the written entries
  // form a prefix; entries beyond it read as zero.
  logic [WW-1:0] anchor_fill;

  always_ff @(posedge clk) begin
    if (rst) begin
      anchor_fill <= '0;
    end else if (s1_go && s1_emit && (WW'(s1_x) >= anchor_fill)) begin
      anchor_fill <= WW'(s1_x) + 1'b1;
    end
  end

  // Previous pixel's mid-row gradient and anchor decision.
  logic [GW-1:0] left_mid;
  logic          prev_anchor;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_mid    <= '0;
      prev_anchor <= 1'b0;
    end else if (s1_go) begin
      left_mid    <= mid_rd;
      prev_anchor <= anchor;
    end
  end

  // Anchor decision: gradient must clear both neighbors by the margin.
  logic [SW-1:0] gm_w;
  logic [SW-1:0] nb_a;
  logic [SW-1:0] nb_b;
  logic [SW-1:0] need_a;
  logic [SW-1:0] need_b;
  logic          earlier;
  logic          above_valid;

  always_comb begin
    above_valid = WW'(s1_x) < anchor_fill;
    gm_w = SW'(mid_rd);
    if (orient_rd) begin
      nb_a    = SW'(left_mid);
      nb_b    = s1_last_col ? '0 : SW'(right_rd);
      earlier = prev_anchor;
    end else begin
      nb_a    = SW'(above_rd);
      nb_b    = SW'(s1_g_in);
      earlier = anchor_rd && above_valid;
    end
    need_a = nb_a + SW'(anchor_thresh);
    need_b = nb_b + SW'(anchor_thresh);
    anchor = s1_emit && !s1_border && (gm_w >= SW'(min_grad)) &&
             (gm_w >= need_a) && (gm_w >= need_b) && !earlier;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_emit) begin
      is_anchor  <= anchor;
      pix_col    <= POS_BITS'(s1_x);
      pix_row    <= s1_row;
      frame_last <= s1_frame_last;
    end
  end

endmodule

@@ tb/tb_edge_anchor_detector.sv @@
// Self-checking testbench for edge_anchor_detector: streams gradient frames, predicts the
// anchor decision of every pixel and compares each output word with the prediction.
// Depends on ead_pkg and the edge_anchor_detector RTL.
module tb_edge_anchor_detector;
  timeunit 1ns;
  timeprecision 1ps;

  import ead_pkg::*;

  localparam int ITEM_TARGET    = 1700;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int XB             = $clog2(MAX_WIDTH_DEF);

  // One decided pixel as it leaves the block.
  typedef struct packed {
    logic                is_anchor;
    logic [POS_BITS-1:0] pix_col;
    logic [POS_BITS-1:0] pix_row;
    logic                frame_last;
  } decision_t;

  typedef struct {
    cfg_reg_t            idx;
    logic [CFG_BITS-1:0] data;
  } reg_write_t;

  // Scoreboard: mirrors the line buffers and counters of the block, predicts the
  // decision caused by each accepted pixel and checks the output words in order.
  class anchor_scoreboard;
    int unsigned min_grad, anchor_thresh, width_reg, height_reg;
    bit [MAG_BITS-1:0] grad_above [MAX_WIDTH_DEF];
    bit [MAG_BITS-1:0] grad_mid [MAX_WIDTH_DEF];
    bit orient_mid [MAX_WIDTH_DEF];
    bit anchor_above [MAX_WIDTH_DEF];
    bit prev_anchor;
    int unsigned left_grad;
    int unsigned col, row;
    decision_t decisions_due[$];
    int errors;

    function new();
      width_reg  = 32'(FRAME_WIDTH_RST);
      height_reg = 32'(FRAME_HEIGHT_RST);
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_BITS-1:0] data);
      case (idx)
        REG_MIN_GRAD:      min_grad = 32'(data);
        REG_ANCHOR_THRESH: anchor_thresh = 32'(data);
        REG_FRAME_WIDTH:   width_reg = 32'(data[DIM_BITS-1:0]);
        REG_FRAME_HEIGHT:  height_reg = 32'(data[DIM_BITS-1:0]);
        default: ;
      endcase
    endfunction

    function int unsigned eff_width();
      if (width_reg < MIN_DIM) return MIN_DIM;
      if (width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
      return width_reg;
    endfunction

    function int unsigned eff_height();
      if (height_reg < MIN_DIM) return MIN_DIM;
      if (height_reg > HEIGHT_LIMIT) return HEIGHT_LIMIT;
      return height_reg;
    endfunction

    // Number of pixels still to send before the current frame is complete.
    function int unsigned pixels_to_frame_end();
      int unsigned w, h, c, r;
      w = eff_width();
      h = eff_height();
      c = col;
      r = row;
      if (c >= w) begin
        c = 0;
        r++;
      end
      if (r >= h) r = 0;
      return (h - 1 - r) * w + (w - c);
    endfunction

    // Advance the mirrored state by one accepted pixel and queue its decision.
    function void note_pixel(logic [MAG_BITS-1:0] mag, logic [ANGLE_BITS-1:0] ang);
      int unsigned w, h, x, y, r, ang_raw, ang_abs;
      int unsigned gm, ga, gl, gr, na, nb, need;
      bit on_border, o_new, anchor, earlier;
      logic [MAG_BITS-1:0] g_new;
      logic [XB-1:0] xi, xn;
      decision_t res;
      w = eff_width();
      h = eff_height();
      // A shrunken frame size moves the position to a new row or frame.
      if (col >= w) begin
        col = 0;
        row++;
      end
      if (row >= h) row = 0;
      x = col;
      y = row;
      xi = XB'(x);
      xn = XB'(x + 1);
      on_border = (x == 0 || x == w - 1 || y == 0 || y == h - 1);
      g_new = on_border ? '0 : mag;

      // Quantize |angle|: near-horizontal gradients compare left and right.
      ang_raw = 32'(ang);
      ang_abs = ang_raw[ANGLE_BITS-1] ? 32'h8000 - ang_raw : ang_raw;
      o_new = (ang_abs < 32'(QUARTER_PI) || ang_abs > 32'(THREE_QUARTER_PI));

      if (y >= 1) begin
        r = y - 1;
        gm = 32'(grad_mid[xi]);
        ga = 32'(grad_above[xi]);
        gl = left_grad;
        gr = (x + 1 < w) ? 32'(grad_mid[xn]) : 0;
        anchor = 1'b0;
        if (!(x == 0 || x == w - 1 || r == 0) && gm >= min_grad) begin
          if (orient_mid[xi]) begin
            na = gl;
            nb = gr;
            earlier = prev_anchor;
          end else begin
            na = ga;
            nb = 32'(g_new);
            earlier = anchor_above[xi];
          end
          need = (na > nb ? na : nb) + anchor_thresh;
          anchor = (gm >= need) && !earlier;
        end
        anchor_above[xi] = anchor;
        prev_anchor = anchor;
        left_grad = gm;
        res.is_anchor  = anchor;
        res.pix_col    = POS_BITS'(x);
        res.pix_row    = POS_BITS'(r);
        res.frame_last = (y == h - 1 && x == w - 1);
        decisions_due.insert(decisions_due.size(), res);
      end else begin
        prev_anchor = 1'b0;
        left_grad = 32'(grad_mid[xi]);
      end

      grad_above[xi] = grad_mid[xi];
      grad_mid[xi] = g_new;
      orient_mid[xi] = o_new;

      col = x + 1;
      if (col >= w) begin
        col = 0;
        row = y + 1;
        if (row >= h) row = 0;
      end
    endfunction

    // Compare one output word with the oldest predicted decision.
    function void check_result(logic anc, logic [POS_BITS-1:0] c, logic [POS_BITS-1:0] r,
                               logic fl);
      decision_t want;
      if (decisions_due.size() == 0) begin
        $error("output word with no pending decision: col %0d row %0d", c, r);
        errors++;
        return;
      end
      want = decisions_due.pop_front();
      if (anc !== want.is_anchor) begin
        $error("is_anchor: expected %0d, actual %0d", want.is_anchor, anc);
        errors++;
      end
      if (c !== want.pix_col) begin
        $error("pix_col: expected %0d, actual %0d", want.pix_col, c);
        errors++;
      end
      if (r !== want.pix_row) begin
        $error("pix_row: expected %0d, actual %0d", want.pix_row, r);
        errors++;
      end
      if (fl !== want.frame_last) begin
        $error("frame_last: expected %0d, actual %0d", want.frame_last, fl);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  cfg_reg_t              cfg_index = REG_MIN_GRAD;
  logic [CFG_BITS-1:0]   cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [MAG_BITS-1:0]   grad_mag = '0;
  logic [ANGLE_BITS-1:0] grad_angle = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  is_anchor;
  logic [POS_BITS-1:0]   pix_col;
  logic [POS_BITS-1:0]   pix_row;
  logic                  frame_last;

  anchor_scoreboard sb;
  reg_write_t       cfg_q[$];
  int unsigned      snd_idle_pct = 0;
  int unsigned      rcv_stall_pct = 0;
  bit               quiet = 1'b0;
  int unsigned      sent_count = 0;

  // Directed frame, 5 x 4: border masking, both orientations, angle limits,
  // and suppression by an anchor to the left and above.
  logic [MAG_BITS-1:0] dir_mag [20] = '{
    16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
    16'hFFFF, 16'd500,  16'd500,  16'd100,  16'hFFFF,
    16'd0,    16'd500,  16'hFFFF, 16'd300,  16'd0,
    16'hFFFF, 16'hFFFF, 16'd0,    16'hFFFF, 16'hFFFF
  };
  int dir_ang [20] = '{
    0,      2047,  2048,  6144,  6145,
    -1,     100,   -2047, 6145,  8192,
    -2048,  2048,  6144,  -6145, -6144,
    -16384, 16383, -8192, 8192,  4096
  };

  edge_anchor_detector u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .grad_mag   (grad_mag),
    .grad_angle (grad_angle),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .is_anchor  (is_anchor),
    .pix_col    (pix_col),
    .pix_row    (pix_row),
    .frame_last (frame_last)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Random gradient content: mostly low values with peaks, angles spread over
  // both orientations and now and then the whole 15-bit range.
  function automatic void draw_pixel(output logic [MAG_BITS-1:0] mag,
                                     output logic [ANGLE_BITS-1:0] ang);
    int v;
    int unsigned sel;
    case ($urandom_range(0, 19))
      0:             mag = 16'hFFFF;
      1:             mag = '0;
      2, 3, 4:       mag = MAG_BITS'($urandom);
      5, 6, 7, 8, 9: mag = MAG_BITS'($urandom_range(256, 4095));
      default:       mag = MAG_BITS'($urandom_range(0, 255));
    endcase
    sel = $urandom_range(0, 9);
    if (sel >= 8) begin
      ang = ANGLE_BITS'($urandom);
    end else begin
      if (sel < 4)
        v = $urandom_range(0, 1) ? $urandom_range(0, 2047) : $urandom_range(6145, 8192);
      else
        v = $urandom_range(2048, 6144);
      ang = $urandom_range(0, 1) ? ANGLE_BITS'(-v) : ANGLE_BITS'(v);
    end
  endfunction

  function automatic logic [CFG_BITS-1:0] pick_level(int unsigned hi);
    case ($urandom_range(0, 9))
      0, 1:    return '0;
      2:       return 16'hFFFF;
      default: return CFG_BITS'($urandom_range(1, hi));
    endcase
  endfunction

  // Frame dimension word: mostly small sizes, sometimes below the minimum,
  // sometimes with junk in the unused upper bits.
  function automatic logic [CFG_BITS-1:0] dim_word(int unsigned hi);
    int unsigned raw;
    logic [3:0] upper;
    raw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, hi);
    upper = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'd0;
    return {upper, DIM_BITS'(raw)};
  endfunction

  task automatic stage_reg(input cfg_reg_t idx, input logic [CFG_BITS-1:0] data);
    reg_write_t w;
    w.idx = idx;
    w.data = data;
    cfg_q.insert(cfg_q.size(), w);
  endtask

  // Drive the staged register writes back to back, one per clock.
  task automatic commit_regs();
    reg_write_t w;
    if (cfg_q.size() == 0) return;
    while (cfg_q.size() != 0) begin
      w = cfg_q.pop_front();
      cfg_write <= 1'b1;
      cfg_index <= w.idx;
      cfg_data <= w.data;
      @(posedge clk);
      sb.write_reg(w.idx, w.data);
    end
    cfg_write <= 1'b0;
  endtask

  // Offer one pixel word, after an optional idle burst, and wait for acceptance.
  task automatic push_pixel(input logic [MAG_BITS-1:0] mag, input logic [ANGLE_BITS-1:0] ang);
    int unsigned gap;
    gap = 0;
    if (!quiet && snd_idle_pct != 0 && $urandom_range(0, 99) < snd_idle_pct)
      gap = $urandom_range(1, 13);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    grad_mag <= mag;
    grad_angle <= ang;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_pixel(mag, ang);
    sent_count++;
  endtask

  task automatic send_pixels(input int unsigned n);
    logic [MAG_BITS-1:0] mag;
    logic [ANGLE_BITS-1:0] ang;
    repeat (n) begin
      draw_pixel(mag, ang);
      push_pixel(mag, ang);
    end
  endtask

  // Stop sending, wait for every pending decision, then let the pipeline empty.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.decisions_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic pick_idling();
    case ($urandom_range(0, 2))
      0:       snd_idle_pct = 0;
      1:       snd_idle_pct = 10;
      default: snd_idle_pct = 40;
    endcase
    case ($urandom_range(0, 3))
      0:       rcv_stall_pct = 0;
      1:       rcv_stall_pct = 15;
      2:       rcv_stall_pct = 50;
      default: rcv_stall_pct = 85;
    endcase
  endtask

  // Receiver: ready in random stretches, stalled in random bursts.
  initial begin
    @(posedge clk);
    forever begin
      if (quiet || rcv_stall_pct == 0) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else if ($urandom_range(0, 99) < rcv_stall_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // Output monitor.
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready)
      sb.check_result(is_anchor, pix_col, pix_row, frame_last);
  end

  // Watchdog: ends the run when neither channel moves a word for too long.
  initial begin
    int unsigned stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  // Main stimulus.
  initial begin
    int unsigned k, w_now, h_now;
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed frame with the reset thresholds of zero.
    stage_reg(REG_FRAME_WIDTH, 16'd5);
    stage_reg(REG_FRAME_HEIGHT, 16'd4);
    commit_regs();
    for (int i = 0; i < 20; i++) push_pixel(dir_mag[5'(i)], ANGLE_BITS'(dir_ang[5'(i)]));

    // Wide frame, three rows tall.
    settle();
    pick_idling();
    stage_reg(REG_MIN_GRAD, 16'd200);
    stage_reg(REG_ANCHOR_THRESH, 16'd0);
    stage_reg(REG_FRAME_WIDTH, 16'd300);
    stage_reg(REG_FRAME_HEIGHT, 16'd3);
    commit_regs();
    send_pixels(sb.pixels_to_frame_end());

    // Tallest frame, cut short: grow past the clamp, then shrink below the
    // current row so the next pixel opens a new frame.
    settle();
    pick_idling();
    stage_reg(REG_MIN_GRAD, 16'd0);
    stage_reg(REG_ANCHOR_THRESH, 16'hFFFF);
    stage_reg(REG_FRAME_WIDTH, 16'hF003);
    stage_reg(REG_FRAME_HEIGHT, 16'h0800);
    commit_regs();
    send_pixels(3 * 40);
    settle();
    stage_reg(REG_FRAME_HEIGHT, 16'hFFFF);
    commit_regs();
    send_pixels(3 * 20);
    settle();
    stage_reg(REG_FRAME_HEIGHT, 16'd5);
    commit_regs();
    send_pixels(sb.pixels_to_frame_end());

    // Random frames under changing settings.
    while (sent_count < ITEM_TARGET) begin
      settle();
      quiet = (sent_count >= ITEM_TARGET * 85 / 100);
      pick_idling();
      if ($urandom_range(0, 3) != 0) stage_reg(REG_MIN_GRAD, pick_level(2000));
      if ($urandom_range(0, 3) != 0) stage_reg(REG_ANCHOR_THRESH, pick_level(400));
      if (sent_count == 0 || $urandom_range(0, 4) != 0)
        stage_reg(REG_FRAME_WIDTH, dim_word(12));
      if (sent_count == 0 || $urandom_range(0, 4) != 0)
        stage_reg(REG_FRAME_HEIGHT, dim_word(8));
      commit_regs();

      // Sometimes pause in the middle of a frame and, mostly, change its size there.
      if ($urandom_range(0, 4) == 0) begin
        k = $urandom_range(1, sb.pixels_to_frame_end() - 1);
        send_pixels(k);
        settle();
        w_now = sb.eff_width();
        h_now = sb.eff_height();
        case ($urandom_range(0, 3))
          0:       stage_reg(REG_FRAME_WIDTH, CFG_BITS'($urandom_range(MIN_DIM, w_now)));
          1:       stage_reg(REG_FRAME_HEIGHT, CFG_BITS'($urandom_range(MIN_DIM, h_now)));
          2:       stage_reg(REG_FRAME_HEIGHT, CFG_BITS'($urandom_range(h_now, h_now + 4)));
          default: ;
        endcase
        commit_regs();
        send_pixels(sb.pixels_to_frame_end());
      end
      repeat ($urandom_range(1, 3)) send_pixels(sb.pixels_to_frame_end());
    end

    // Drain and report.
    in_valid <= 1'b0;
    while (sb.decisions_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
